// ----- design/cleb_pkg.sv -----
`default_nettype none
package cleb_pkg;

	localparam int unsigned DEFAULT_CAPACITY = 256;
	localparam int unsigned KEY_W = 8;
	localparam int unsigned IDX_W = 8;

	localparam logic [KEY_W-1:0] KEY_NEWLINE   = 8'h52;
	localparam logic [KEY_W-1:0] KEY_BACKSPACE = 8'h42;
	localparam logic [KEY_W-1:0] KEY_DELETE    = 8'h44;
	localparam logic [KEY_W-1:0] KEY_LEFT      = 8'h3C;
	localparam logic [KEY_W-1:0] KEY_RIGHT     = 8'h3E;
	localparam logic [KEY_W-1:0] NEWLINE_CHAR  = 8'h0A;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// decoded request, carried from the decoder into the first stage
	typedef struct packed {
		logic             rd_en;
		logic             we;
		logic             mv;
		logic             isrd;
		logic [KEY_W-1:0] wdata;
		status_t          status;
	} op_t;

endpackage
`default_nettype wire

// ----- design/cleb_decode.sv -----
`default_nettype none
module cleb_decode #(
	parameter int unsigned CAPACITY = cleb_pkg::DEFAULT_CAPACITY
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           accept,
	input  wire logic                           kind,
	input  wire logic [cleb_pkg::KEY_W-1:0]     key_byte,
	input  wire logic [cleb_pkg::IDX_W-1:0]     read_index,
	output cleb_pkg::op_t                       op,
	output logic [$clog2(CAPACITY)-1:0]         rd_addr,
	output logic [$clog2(CAPACITY)-1:0]         wr_addr,
	output logic [$clog2(CAPACITY+1)-1:0]       next_len,
	output logic [$clog2(CAPACITY+1)-1:0]       next_left
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY+1);
	localparam int unsigned IW = (CW > cleb_pkg::IDX_W) ? CW : cleb_pkg::IDX_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	logic [CW-1:0] left_q;
	logic [CW-1:0] right_q;
	logic [CW-1:0] nl;
	logic [CW-1:0] nr;
	logic [CW-1:0] len;
	logic [CW-1:0] cap_m_len;
	logic [IW-1:0] idx_x;
	logic [IW-1:0] len_x;
	logic [IW-1:0] left_x;
	logic [cleb_pkg::KEY_W-1:0] ins_char;

	assign len       = left_q + right_q;
	assign cap_m_len = CAP_C - len;
	assign idx_x     = IW'(read_index);
	assign len_x     = IW'(len);
	assign left_x    = IW'(left_q);
	assign ins_char  = (key_byte == cleb_pkg::KEY_NEWLINE) ? cleb_pkg::NEWLINE_CHAR : key_byte;

	always_comb begin
		op        = '0;
		op.status = cleb_pkg::ST_OK;
		nl        = left_q;
		nr        = right_q;
		rd_addr   = '0;
		wr_addr   = '0;
		if (kind) begin
			if (idx_x >= len_x) begin
				op.status = cleb_pkg::ST_RANGE;
			end else begin
				op.rd_en = 1'b1;
				op.isrd  = 1'b1;
				// right part sits at the top end of the store
				if (idx_x < left_x) begin
					rd_addr = AW'(idx_x);
				end else begin
					rd_addr = AW'(cap_m_len + CW'(idx_x));
				end
			end
		end else begin
			unique case (key_byte)
				cleb_pkg::KEY_BACKSPACE: begin
					if (left_q != '0) nl = left_q - ONE_C;
				end
				cleb_pkg::KEY_DELETE: begin
					if (right_q != '0) nr = right_q - ONE_C;
				end
				cleb_pkg::KEY_LEFT: begin
					if (left_q != '0) begin
						op.rd_en = 1'b1;
						op.we    = 1'b1;
						op.mv    = 1'b1;
						rd_addr  = AW'(left_q - ONE_C);
						wr_addr  = AW'(CAP_C - right_q - ONE_C);
						nl       = left_q - ONE_C;
						nr       = right_q + ONE_C;
					end
				end
				cleb_pkg::KEY_RIGHT: begin
					if (right_q != '0) begin
						op.rd_en = 1'b1;
						op.we    = 1'b1;
						op.mv    = 1'b1;
						rd_addr  = AW'(CAP_C - right_q);
						wr_addr  = AW'(left_q);
						nl       = left_q + ONE_C;
						nr       = right_q - ONE_C;
					end
				end
				default: begin
					if (len == CAP_C) begin
						op.status = cleb_pkg::ST_FULL;
					end else begin
						op.we    = 1'b1;
						op.wdata = ins_char;
						wr_addr  = AW'(left_q);
						nl       = left_q + ONE_C;
					end
				end
			endcase
		end
	end

	assign next_len  = nl + nr;
	assign next_left = nl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			right_q <= '0;
		end else if (accept) begin
			left_q  <= nl;
			right_q <= nr;
		end
	end

endmodule
`default_nettype wire

// ----- design/cleb_store.sv -----
`default_nettype none
module cleb_store #(
	parameter int unsigned CAPACITY = cleb_pkg::DEFAULT_CAPACITY
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rd_en,
	input  wire logic [$clog2(CAPACITY)-1:0]   rd_addr,
	input  wire logic                          wr_en,
	input  wire logic [$clog2(CAPACITY)-1:0]   wr_addr,
	input  wire logic [cleb_pkg::KEY_W-1:0]    wr_data,
	output logic [cleb_pkg::KEY_W-1:0]         rd_data
);

	logic [cleb_pkg::KEY_W-1:0] mem [CAPACITY];
	logic [cleb_pkg::KEY_W-1:0] rd_q;
	logic [cleb_pkg::KEY_W-1:0] fwd_data_q;
	logic                       fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// a read issued on the edge of a write to the same entry sees the new data, forwarded from the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;

endmodule
`default_nettype wire

// ----- design/cursor_line_edit_buffer.sv -----
`default_nettype none
// channel  signals                               direction  request
// in       in_valid, in_ready                    into block kind, key_byte, read_index
// out      out_valid, out_ready                  from block char_out, text_length,
//                                                           cursor_pos, status
// a request passes decode and store read into the first stage, then write back as it moves to the result stage
// one request per cycle sustained while out_ready holds; the single store write port takes the cursor move copy
// arst_n clears counts and valid flags; store contents are undefined until written
// a stalled result holds the first stage, and in_ready drops only then
module cursor_line_edit_buffer #(
	parameter int unsigned CAPACITY = cleb_pkg::DEFAULT_CAPACITY
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             kind,
	input  wire logic [cleb_pkg::KEY_W-1:0]       key_byte,
	input  wire logic [cleb_pkg::IDX_W-1:0]       read_index,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [cleb_pkg::KEY_W-1:0]            char_out,
	output logic [$clog2(CAPACITY+1)-1:0]         text_length,
	output logic [$clog2(CAPACITY+1)-1:0]         cursor_pos,
	output logic [1:0]                            status
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY+1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic                       accept;
	logic                       advance;
	cleb_pkg::op_t              op;
	logic [AW-1:0]              rd_addr;
	logic [AW-1:0]              wr_addr;
	logic [CW-1:0]              next_len;
	logic [CW-1:0]              next_left;
	logic                       mem_we;
	logic [cleb_pkg::KEY_W-1:0] mem_wdata;
	logic [cleb_pkg::KEY_W-1:0] rd_data;

	logic                       valid_s1;
	cleb_pkg::op_t              op_s1;
	logic [AW-1:0]              waddr_s1;
	logic [CW-1:0]              len_s1;
	logic [CW-1:0]              cur_s1;

	logic                       valid_s2;
	logic [cleb_pkg::KEY_W-1:0] char_s2;
	logic [CW-1:0]              len_s2;
	logic [CW-1:0]              cur_s2;
	cleb_pkg::status_t          status_s2;

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	cleb_decode #(.CAPACITY(CAPACITY)) u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.kind       (kind),
		.key_byte   (key_byte),
		.read_index (read_index),
		.op         (op),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.next_len   (next_len),
		.next_left  (next_left)
	);

	// the write back of the first stage lands as it moves on
	assign mem_we    = valid_s1 && advance && op_s1.we;
	assign mem_wdata = op_s1.mv ? rd_data : op_s1.wdata;

	cleb_store #(.CAPACITY(CAPACITY)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && op.rd_en),
		.rd_addr (rd_addr),
		.wr_en   (mem_we),
		.wr_addr (waddr_s1),
		.wr_data (mem_wdata),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op;
			waddr_s1 <= wr_addr;
			len_s1   <= next_len;
			cur_s1   <= next_left;
		end
		if (advance && valid_s1) begin
			char_s2   <= op_s1.isrd ? rd_data : '0;
			len_s2    <= len_s1;
			cur_s2    <= cur_s1;
			status_s2 <= op_s1.status;
		end
	end

	assign out_valid   = valid_s2;
	assign char_out    = char_s2;
	assign text_length = len_s2;
	assign cursor_pos  = cur_s2;
	assign status      = status_s2;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (len_s2 <= CAP_C && cur_s2 <= len_s2))
		else $error("text length or cursor out of bounds");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && status_s2 == cleb_pkg::ST_FULL) |-> (len_s2 == CAP_C && char_s2 == '0))
		else $error("insert dropped while buffer not full");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("input stalled without an output stall");

	a_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> !(valid_s1 && $stable(waddr_s1) && !$past(accept)))
		else $error("store write repeated for one request");

	a_range_char: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && status_s2 == cleb_pkg::ST_RANGE) |-> (char_s2 == '0))
		else $error("failed read returned a character");

endmodule
`default_nettype wire
